@@ rtl/gain_sorted_user_pairing_macros.svh @@
// ----------------------------------------------------------------------------
// gain_sorted_user_pairing_macros
// Assertion helpers shared by the pairing block.
// ----------------------------------------------------------------------------
`ifndef GAIN_SORTED_USER_PAIRING_MACROS_SVH
`define GAIN_SORTED_USER_PAIRING_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GSUP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GSUP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gsup_pkg.sv @@
// ----------------------------------------------------------------------------
// gsup_pkg
// Types and constants shared by the gain-sorted user pairing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsup_pkg;

  // Register defaults, Q0.16 (0.8 and 0.2 rounded to nearest)
  localparam logic [15:0] HIGH_SHARE_RST = 16'd52429;
  localparam logic [15:0] LOW_SHARE_RST  = 16'd13107;

  // Register indexes (word address bit 2)
  localparam logic REG_HIGH_SHARE = 1'b0;
  localparam logic REG_LOW_SHARE  = 1'b1;

  // Pairing role of a result
  typedef enum logic [1:0] {
    ROLE_STRONG   = 2'd0,
    ROLE_WEAK     = 2'd1,
    ROLE_UNPAIRED = 2'd2
  } role_e;

  // Controller state
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // Commands broadcast along the sorting chain
  typedef struct packed {
    logic insert;  // place the incoming user in the sorted row
    logic shift;   // move every entry one cell toward the head
  } chain_ctl_t;

endpackage

@@ rtl/gsup_cell.sv @@
// ----------------------------------------------------------------------------
// gsup_cell
// One cell of the systolic insertion sorter: holds one user, either keeps it, takes the
// incoming user, or takes its upstream neighbor's user on insert (downstream on shift).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsup_cell
  import gsup_pkg::*;
#(
  parameter int GAIN_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chain_ctl_t           ctl_i,
  // incoming user
  input  logic [GAIN_BITS-1:0] new_gain_i,
  input  logic [15:0]          new_id_i,
  // neighbor toward the head (lower rank)
  input  logic                 prev_ins_i,
  input  logic                 prev_valid_i,
  input  logic [GAIN_BITS-1:0] prev_gain_i,
  input  logic [15:0]          prev_id_i,
  // neighbor toward the tail (higher rank)
  input  logic                 next_valid_i,
  input  logic [GAIN_BITS-1:0] next_gain_i,
  input  logic [15:0]          next_id_i,
  // this cell
  output logic                 ins_o,
  output logic                 valid_o,
  output logic [GAIN_BITS-1:0] gain_o,
  output logic [15:0]          id_o
);

  logic                 valid_q, valid_d;
  logic [GAIN_BITS-1:0] gain_q, gain_d;
  logic [15:0]          id_q, id_d;

  // New user goes ahead of this entry (ties keep arrival order)
  assign ins_o = !valid_q || (gain_q < new_gain_i);

  always_comb begin
    valid_d = valid_q;
    gain_d  = gain_q;
    id_d    = id_q;
    if (ctl_i.shift) begin
      valid_d = next_valid_i;
      gain_d  = next_gain_i;
      id_d    = next_id_i;
    end else if (ctl_i.insert && ins_o) begin
      if (prev_ins_i) begin
        valid_d = prev_valid_i;
        gain_d  = prev_gain_i;
        id_d    = prev_id_i;
      end else begin
        valid_d = 1'b1;
        gain_d  = new_gain_i;
        id_d    = new_id_i;
      end
    end
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
    id_q   <= id_d;
  end

  assign valid_o = valid_q;
  assign gain_o  = gain_q;
  assign id_o    = id_q;

endmodule

@@ rtl/gsup_ctrl.sv @@
// ----------------------------------------------------------------------------
// gsup_ctrl
// Load/emit sequencer: counts users, tracks overflow, and derives rank,
// role and pair index of each emitted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gain_sorted_user_pairing_macros.svh"

module gsup_ctrl
  import gsup_pkg::*;
#(
  parameter int MAX_USERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_last_i,
  output logic       s_ready_o,
  input  logic       m_ready_i,
  output logic       m_valid_o,
  output chain_ctl_t ctl_o,
  output role_e      role_o,
  output logic [4:0] pair_index_o,
  output logic       overflow_o,
  output logic       last_o
);

  localparam int CW = $clog2(MAX_USERS + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rank_q, rank_d;
  logic          ovf_q, ovf_d;

  logic          in_fire, out_fire, room;
  logic [CW-1:0] half, pair;

  assign room     = count_q < CW'(MAX_USERS);
  assign in_fire  = s_valid_i && (state_q == ST_LOAD);
  assign out_fire = m_ready_i && (state_q == ST_EMIT);
  assign last_o   = (rank_q == (count_q - CW'(1)));

  // Next state, counters, chain commands
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rank_d       = rank_q;
    ovf_d        = ovf_q;
    ctl_o.insert = 1'b0;
    ctl_o.shift  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (room) begin
            ctl_o.insert = 1'b1;
            count_d      = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_last_i) begin
            state_d = ST_EMIT;
            rank_d  = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          ctl_o.shift = 1'b1;
          rank_d      = rank_q + CW'(1);
          if (last_o) begin
            state_d = ST_LOAD;
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      rank_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rank_q  <= rank_d;
      ovf_q   <= ovf_d;
    end
  end

  // Role and pair index of the current rank
  assign half = count_q >> 1;
  always_comb begin
    if (rank_q < half) begin
      role_o = ROLE_STRONG;
      pair   = rank_q;
    end else if (rank_q >= (count_q - half)) begin
      role_o = ROLE_WEAK;
      pair   = count_q - CW'(1) - rank_q;
    end else begin
      role_o = ROLE_UNPAIRED;
      pair   = rank_q;
    end
  end

  assign pair_index_o = 5'(pair);
  assign overflow_o   = ovf_q;
  assign s_ready_o    = (state_q == ST_LOAD);
  assign m_valid_o    = (state_q == ST_EMIT);

  `GSUP_ASSERT(a_rank_in_set, clk_i, rst_ni, (state_q == ST_EMIT) |-> (rank_q < count_q), "rank past user count")
  `GSUP_ASSERT(a_count_cap, clk_i, rst_ni, count_q <= CW'(MAX_USERS), "user count above capacity")
  `GSUP_ASSERT_NEXT(a_emit_after_last, clk_i, rst_ni, in_fire && s_last_i, (state_q == ST_EMIT) && (rank_q == '0), "last user did not start output")
  `GSUP_ASSERT_NEXT(a_clear_after_set, clk_i, rst_ni, out_fire && last_o, (state_q == ST_LOAD) && (count_q == '0) && !ovf_q, "set not cleared after final result")

endmodule

@@ rtl/gain_sorted_user_pairing.sv @@
// Loads one user per cycle while idle-for-input (tready high) into a chain of sorting cells.
// The item marked last ends loading; the first result is offered the next cycle.
// Results stream at one per cycle from the head cell while m_axis_tready is high.
// No input is taken while a set is being emitted.
// Reset empties the chain, clears count and overflow, restores the default power shares.
// ----------------------------------------------------------------------------
// gain_sorted_user_pairing
// Channel-gain sorted user pairing: systolic insertion sort by gain, then
// strong/weak pairing of ranks i and N-1-i with configurable power shares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gain_sorted_user_pairing
  import gsup_pkg::*;
#(
  parameter int MAX_USERS = 64,
  parameter int GAIN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // user stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // user_id[15:0], gain[31:16]
  input  logic        s_axis_tlast,   // last_user
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_user_id[15:0], out_gain[31:16], power_share[47:32], role[49:48],
  // pair_index[54:50], overflow[55]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_result
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  chain_ctl_t           ctl;
  role_e                role;
  logic [4:0]           pair_index;
  logic                 overflow, last_res;
  logic [15:0]          high_share_q, low_share_q;
  logic [15:0]          share;
  logic [GAIN_BITS-1:0] new_gain;

  logic                 ins_w   [MAX_USERS];
  logic                 valid_w [MAX_USERS];
  logic [GAIN_BITS-1:0] gain_w  [MAX_USERS];
  logic [15:0]          id_w    [MAX_USERS];

  // Register port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_share_q <= HIGH_SHARE_RST;
      low_share_q  <= LOW_SHARE_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HIGH_SHARE) begin
        high_share_q <= pwdata[15:0];
      end else begin
        low_share_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HIGH_SHARE) begin
      prdata[15:0] = high_share_q;
    end else begin
      prdata[15:0] = low_share_q;
    end
  end

  // Sequencer
  gsup_ctrl #(
    .MAX_USERS (MAX_USERS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_last_i     (s_axis_tlast),
    .s_ready_o    (s_axis_tready),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .ctl_o        (ctl),
    .role_o       (role),
    .pair_index_o (pair_index),
    .overflow_o   (overflow),
    .last_o       (last_res)
  );

  assign new_gain = GAIN_BITS'(s_axis_tdata[31:16]);

  // Sorting chain, cell 0 holds the highest gain
  for (genvar k = 0; k < MAX_USERS; k++) begin : g_cell
    logic                 p_ins, p_valid, n_valid;
    logic [GAIN_BITS-1:0] p_gain, n_gain;
    logic [15:0]          p_id, n_id;

    if (k == 0) begin : g_head
      assign p_ins   = 1'b0;
      assign p_valid = 1'b0;
      assign p_gain  = '0;
      assign p_id    = '0;
    end else begin : g_body
      assign p_ins   = ins_w[k-1];
      assign p_valid = valid_w[k-1];
      assign p_gain  = gain_w[k-1];
      assign p_id    = id_w[k-1];
    end

    if (k == MAX_USERS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_gain  = '0;
      assign n_id    = '0;
    end else begin : g_inner
      assign n_valid = valid_w[k+1];
      assign n_gain  = gain_w[k+1];
      assign n_id    = id_w[k+1];
    end

    gsup_cell #(
      .GAIN_BITS (GAIN_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_gain_i   (new_gain),
      .new_id_i     (s_axis_tdata[15:0]),
      .prev_ins_i   (p_ins),
      .prev_valid_i (p_valid),
      .prev_gain_i  (p_gain),
      .prev_id_i    (p_id),
      .next_valid_i (n_valid),
      .next_gain_i  (n_gain),
      .next_id_i    (n_id),
      .ins_o        (ins_w[k]),
      .valid_o      (valid_w[k]),
      .gain_o       (gain_w[k]),
      .id_o         (id_w[k])
    );
  end

  // Power share by role
  always_comb begin
    unique case (role)
      ROLE_STRONG: share = high_share_q;
      ROLE_WEAK:   share = low_share_q;
      default:     share = '0;
    endcase
  end

  // Result packing from the head cell
  assign m_axis_tdata = {overflow, pair_index, role, share, 16'(gain_w[0]), id_w[0]};
  assign m_axis_tlast = last_res;

endmodule
